/* rtl/core/lrpf_pkg.sv */
// Package for the page-framebuffer line rasterizer.
// Holds transaction structs, register indexes and opcode constants.
// No dependencies.
package lrpf_pkg;

  // Coordinate width of the endpoint and pixel fields
  localparam int COORD_BITS = 12;

  // Configuration register widths and indexes
  localparam int WIDTH_BITS  = 11;
  localparam int BYTES_BITS  = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUFFER_BYTES  = 2'd2;

  localparam logic [WIDTH_BITS-1:0] SCREEN_WIDTH_RST  = 11'd128;
  localparam logic [WIDTH_BITS-1:0] SCREEN_HEIGHT_RST = 11'd64;
  localparam logic [BYTES_BITS-1:0] BUFFER_BYTES_RST  = 16'd1024;

  // Opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Log2 of rows per page and bit-position width
  localparam int PAGE_SHIFT = 3;
  localparam int BIT_POS_BITS = 3;

  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic                         ink;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pix_x;
    logic signed [COORD_BITS-1:0] pix_y;
    logic                         visible;
    logic [BYTES_BITS-1:0]        byte_index;
    logic [BIT_POS_BITS-1:0]      bit_pos;
    logic                         set_bit;
    logic                         last;
  } out_item_t;

endpackage

/* rtl/core/line_rasterizer_page_framebuffer_top.sv */
// Bresenham line rasterizer driving a 1-bit vertical-page framebuffer.
// Depends on lrpf_pkg for transaction structs and constants.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes two kinds of transaction.
//   A start transaction loads both endpoints and the ink and produces nothing.
//   Each step transaction produces the next pixel of the active line on the
//   result channel (out_valid/out_ready/out_data): coordinates, framebuffer
//   byte index, bit position, ink and a visible flag; the endpoint pixel is
//   flagged last and ends the line. A step with no active line produces nothing.
//   A result is registered and appears in the cycle after its step is accepted.
//   Throughput: one transaction per cycle; the stepper state, the page index
//   multiply and the bounds compares all complete in the accepting cycle.
//   When the receiver stalls, the result register holds its transaction and
//   in_ready drops until it is taken; no transaction is lost or repeated.
//   Reset (rst_n low, synchronous) drops any active line, empties the result
//   register and loads the register defaults: width 128, height 64, 1024 bytes.
//   Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once;
//   index 3 is ignored.
module line_rasterizer_page_framebuffer_top
  import lrpf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data
);

  localparam int ERR_BITS  = COORD_BITS + 2;
  localparam int E2_BITS   = ERR_BITS + 1;
  localparam int SUM_BITS  = ERR_BITS + 2;
  localparam int ROW_BITS  = COORD_BITS - PAGE_SHIFT;
  localparam int PROD_BITS = ROW_BITS + WIDTH_BITS;
  localparam int IDX_BITS  = PROD_BITS + 1;
  localparam int CMP_BITS  = (COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS;

  // Configuration registers
  logic [WIDTH_BITS-1:0] screen_width_r;
  logic [WIDTH_BITS-1:0] screen_height_r;
  logic [BYTES_BITS-1:0] buffer_bytes_r;

  // Line state
  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic signed [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] target_x_r, target_x_nxt;
  logic signed [COORD_BITS-1:0] target_y_r, target_y_nxt;
  logic [COORD_BITS-1:0]        delta_x_r, delta_x_nxt;
  logic signed [COORD_BITS:0]   neg_delta_y_r, neg_delta_y_nxt;
  logic                         step_x_neg_r, step_x_neg_nxt;
  logic                         step_y_neg_r, step_y_neg_nxt;
  logic signed [ERR_BITS-1:0]   error_term_r, error_term_nxt;
  logic                         line_ink_r, line_ink_nxt;
  logic                         busy_r, busy_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Handshake
  logic in_fire;
  logic is_step;
  logic produce;

  // Start-time arithmetic
  logic signed [COORD_BITS:0] x0_ext, x1_ext, y0_ext, y1_ext;
  logic signed [COORD_BITS:0] dx_fwd, dx_rev, dy_fwd, dy_rev;
  logic                       x_gt, y_gt;
  logic [COORD_BITS-1:0]      start_dx;
  logic signed [COORD_BITS:0] start_ndy;

  // Step arithmetic
  logic signed [E2_BITS-1:0]  e2;
  logic signed [E2_BITS-1:0]  ndy_e2;
  logic signed [E2_BITS-1:0]  dx_e2;
  logic                       move_x, move_y;
  logic signed [SUM_BITS-1:0] err_sum;
  logic                       fin;

  // Pixel address
  logic                  on_screen;
  logic [CMP_BITS-1:0]   ux_cmp, uy_cmp, w_cmp, h_cmp;
  logic [ROW_BITS-1:0]   page_row;
  logic [PROD_BITS-1:0]  page_off;
  logic [IDX_BITS-1:0]   idx_full;
  logic [BYTES_BITS-1:0] idx;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_step   = (in_data.op == OP_STEP);
  assign produce   = in_fire && is_step && busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Endpoint deltas for a start transaction
  assign x0_ext   = {in_data.start_x[COORD_BITS-1], in_data.start_x};
  assign x1_ext   = {in_data.end_x[COORD_BITS-1], in_data.end_x};
  assign y0_ext   = {in_data.start_y[COORD_BITS-1], in_data.start_y};
  assign y1_ext   = {in_data.end_y[COORD_BITS-1], in_data.end_y};
  assign dx_fwd   = x1_ext - x0_ext;
  assign dx_rev   = x0_ext - x1_ext;
  assign dy_fwd   = y1_ext - y0_ext;
  assign dy_rev   = y0_ext - y1_ext;
  assign x_gt     = (in_data.end_x > in_data.start_x);
  assign y_gt     = (in_data.end_y > in_data.start_y);
  assign start_dx = x_gt ? dx_fwd[COORD_BITS-1:0] : dx_rev[COORD_BITS-1:0];
  assign start_ndy = y_gt ? dy_rev : dy_fwd;

  // Bresenham decision on the doubled error
  assign e2      = {error_term_r, 1'b0};
  assign ndy_e2  = {{(E2_BITS-COORD_BITS-1){neg_delta_y_r[COORD_BITS]}}, neg_delta_y_r};
  assign dx_e2   = {{(E2_BITS-COORD_BITS){1'b0}}, delta_x_r};
  assign move_x  = (e2 >= ndy_e2);
  assign move_y  = (e2 <= dx_e2);
  assign err_sum = {{(SUM_BITS-ERR_BITS){error_term_r[ERR_BITS-1]}}, error_term_r}
                 + (move_x ? SUM_BITS'(ndy_e2) : '0)
                 + (move_y ? SUM_BITS'(dx_e2) : '0);
  assign fin     = (cur_x_r == target_x_r) && (cur_y_r == target_y_r);

  // Screen bounds and page-byte address
  assign ux_cmp    = CMP_BITS'(unsigned'(cur_x_r));
  assign uy_cmp    = CMP_BITS'(unsigned'(cur_y_r));
  assign w_cmp     = CMP_BITS'(screen_width_r);
  assign h_cmp     = CMP_BITS'(screen_height_r);
  assign on_screen = !cur_x_r[COORD_BITS-1] && !cur_y_r[COORD_BITS-1]
                   && (ux_cmp < w_cmp) && (uy_cmp < h_cmp);
  assign page_row  = cur_y_r[COORD_BITS-1:PAGE_SHIFT];
  assign page_off  = PROD_BITS'(page_row) * PROD_BITS'(screen_width_r);
  assign idx_full  = IDX_BITS'(unsigned'(cur_x_r)) + IDX_BITS'(page_off);
  assign idx       = idx_full[BYTES_BITS-1:0];

  // Next line state
  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    target_x_nxt    = target_x_r;
    target_y_nxt    = target_y_r;
    delta_x_nxt     = delta_x_r;
    neg_delta_y_nxt = neg_delta_y_r;
    step_x_neg_nxt  = step_x_neg_r;
    step_y_neg_nxt  = step_y_neg_r;
    error_term_nxt  = error_term_r;
    line_ink_nxt    = line_ink_r;
    busy_nxt        = busy_r;
    if (in_fire && !is_step) begin
      // Load a new line, dropping any active one
      cur_x_nxt       = in_data.start_x;
      cur_y_nxt       = in_data.start_y;
      target_x_nxt    = in_data.end_x;
      target_y_nxt    = in_data.end_y;
      delta_x_nxt     = start_dx;
      neg_delta_y_nxt = start_ndy;
      step_x_neg_nxt  = !(in_data.start_x < in_data.end_x);
      step_y_neg_nxt  = !(in_data.start_y < in_data.end_y);
      error_term_nxt  = ERR_BITS'(signed'({2'b00, start_dx}))
                      + ERR_BITS'(start_ndy);
      line_ink_nxt    = in_data.ink;
      busy_nxt        = 1'b1;
    end else if (produce) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else begin
        // Advance along the major and minor axes
        error_term_nxt = err_sum[ERR_BITS-1:0];
        if (move_x) begin
          cur_x_nxt = step_x_neg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
        end
        if (move_y) begin
          cur_y_nxt = step_y_neg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
        end
      end
    end
  end

  // Next result register contents
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_ready) begin
      out_valid_nxt            = produce;
      out_data_nxt.pix_x       = cur_x_r;
      out_data_nxt.pix_y       = cur_y_r;
      out_data_nxt.visible     = on_screen && (idx < buffer_bytes_r);
      out_data_nxt.byte_index  = on_screen ? idx : '0;
      out_data_nxt.bit_pos     = on_screen ? cur_y_r[BIT_POS_BITS-1:0] : '0;
      out_data_nxt.set_bit     = line_ink_r;
      out_data_nxt.last        = fin;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      buffer_bytes_r  <= BUFFER_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[WIDTH_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[WIDTH_BITS-1:0];
        REG_BUFFER_BYTES:  buffer_bytes_r  <= cfg_wdata[BYTES_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      target_x_r    <= '0;
      target_y_r    <= '0;
      delta_x_r     <= '0;
      neg_delta_y_r <= '0;
      step_x_neg_r  <= 1'b0;
      step_y_neg_r  <= 1'b0;
      error_term_r  <= '0;
      line_ink_r    <= 1'b0;
      busy_r        <= 1'b0;
    end else begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      target_x_r    <= target_x_nxt;
      target_y_r    <= target_y_nxt;
      delta_x_r     <= delta_x_nxt;
      neg_delta_y_r <= neg_delta_y_nxt;
      step_x_neg_r  <= step_x_neg_nxt;
      step_y_neg_r  <= step_y_neg_nxt;
      error_term_r  <= error_term_nxt;
      line_ink_r    <= line_ink_nxt;
      busy_r        <= busy_nxt;
    end
  end

  // Result register: valid is control, payload holds without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

/* test/line_rasterizer_page_framebuffer_top_tb.sv */
// Self-checking testbench for the page-framebuffer line rasterizer.
// Predicts each pixel transaction and checks it field by field; depends on
// lrpf_pkg and line_rasterizer_page_framebuffer_top.
module line_rasterizer_page_framebuffer_top_tb;
  import lrpf_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 230;

  // Predicts the pixel stream and holds the pixels still owed by the block
  class raster_scoreboard;
    logic [WIDTH_BITS-1:0] scr_w;
    logic [WIDTH_BITS-1:0] scr_h;
    logic [BYTES_BITS-1:0] buf_bytes;
    int pen_x, pen_y, goal_x, goal_y;
    int run_x, rise_neg, err_acc;
    bit x_back, y_back, ink_on, drawing;
    out_item_t pixels_due[$];
    int mismatches;
    int live_count;

    function new();
      scr_w      = SCREEN_WIDTH_RST;
      scr_h      = SCREEN_HEIGHT_RST;
      buf_bytes  = BUFFER_BYTES_RST;
      pen_x      = 0;
      pen_y      = 0;
      goal_x     = 0;
      goal_y     = 0;
      run_x      = 0;
      rise_neg   = 0;
      err_acc    = 0;
      x_back     = 1'b0;
      y_back     = 1'b0;
      ink_on     = 1'b0;
      drawing    = 1'b0;
      mismatches = 0;
      live_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  scr_w = val[WIDTH_BITS-1:0];
        REG_SCREEN_HEIGHT: scr_h = val[WIDTH_BITS-1:0];
        REG_BUFFER_BYTES:  buf_bytes = val[BYTES_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Note an accepted input transaction and queue the pixel it produces
    function void note_input(in_item_t it);
      out_item_t px;
      int addr;
      int twice;
      if (it.op == OP_START) begin
        pen_x    = int'($signed(it.start_x));
        pen_y    = int'($signed(it.start_y));
        goal_x   = int'($signed(it.end_x));
        goal_y   = int'($signed(it.end_y));
        run_x    = (goal_x > pen_x) ? goal_x - pen_x : pen_x - goal_x;
        rise_neg = (goal_y > pen_y) ? pen_y - goal_y : goal_y - pen_y;
        x_back   = !(pen_x < goal_x);
        y_back   = !(pen_y < goal_y);
        err_acc  = run_x + rise_neg;
        ink_on   = it.ink;
        drawing  = 1'b1;
        live_count++;
        return;
      end
      if (!drawing) return;

      px = '0;
      px.pix_x = pen_x[COORD_BITS-1:0];
      px.pix_y = pen_y[COORD_BITS-1:0];
      // Byte address and bit only for pixels on the screen
      if (pen_x >= 0 && pen_y >= 0 && pen_x < int'(scr_w) && pen_y < int'(scr_h)) begin
        addr = (pen_x + (pen_y >> PAGE_SHIFT) * int'(scr_w)) & 'hFFFF;
        px.byte_index = addr[BYTES_BITS-1:0];
        px.bit_pos    = pen_y[BIT_POS_BITS-1:0];
        px.visible    = (addr < int'(buf_bytes));
      end
      px.set_bit = ink_on;
      px.last    = (pen_x == goal_x) && (pen_y == goal_y);
      pixels_due.push_back(px);
      live_count++;

      // Advance the pen along the line, or end it on the endpoint
      if (px.last) begin
        drawing = 1'b0;
      end else begin
        twice = 2 * err_acc;
        if (twice >= rise_neg) begin
          err_acc += rise_neg;
          pen_x   += x_back ? -1 : 1;
        end
        if (twice <= run_x) begin
          err_acc += run_x;
          pen_y   += y_back ? -1 : 1;
        end
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Check a result transaction against the oldest predicted pixel
    function void check_result(out_item_t got);
      out_item_t want;
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d",
                 $time, got.pix_x, got.pix_y);
        mismatches++;
        return;
      end
      want = pixels_due.pop_front();
      compare("pix_x", 32'(want.pix_x), 32'(got.pix_x));
      compare("pix_y", 32'(want.pix_y), 32'(got.pix_y));
      compare("visible", 32'(want.visible), 32'(got.visible));
      compare("byte_index", 32'(want.byte_index), 32'(got.byte_index));
      compare("bit_pos", 32'(want.bit_pos), 32'(got.bit_pos));
      compare("set_bit", 32'(want.set_bit), 32'(got.set_bit));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_data;

  raster_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  line_rasterizer_page_framebuffer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Pace the receiver; hold off for a long stretch on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Check results and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("line_rasterizer_page_framebuffer_top regression: fail");
      $finish;
    end
  end

  function automatic int rand_coord();
    logic [31:0] r;
    r = $urandom;
    return int'($signed(r[COORD_BITS-1:0]));
  endfunction

  function automatic int clip_coord(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic int line_steps(int x0, int y0, int x1, int y1);
    int ax, ay;
    ax = (x1 > x0) ? x1 - x0 : x0 - x1;
    ay = (y1 > y0) ? y1 - y0 : y0 - y1;
    return ((ax > ay) ? ax : ay) + 1;
  endfunction

  function automatic in_item_t random_item();
    logic [31:0] a, b;
    in_item_t it;
    a = $urandom;
    b = $urandom;
    it.op      = a[0];
    it.start_x = a[12:1];
    it.start_y = a[24:13];
    it.end_x   = b[11:0];
    it.end_y   = b[23:12];
    it.ink     = b[24];
    return it;
  endfunction

  // Offer one transaction, idling first at random; valid stays up until taken
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_start(int x0, int y0, int x1, int y1, bit ink);
    in_item_t it;
    it = random_item();
    it.op      = OP_START;
    it.start_x = x0[COORD_BITS-1:0];
    it.start_y = y0[COORD_BITS-1:0];
    it.end_x   = x1[COORD_BITS-1:0];
    it.end_y   = y1[COORD_BITS-1:0];
    it.ink     = ink;
    send_item(it);
  endtask

  // Step items carry random endpoint fields, which the block ignores
  task automatic send_steps(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = random_item();
      it.op = OP_STEP;
      send_item(it);
    end
  endtask

  // Drain outstanding pixels, then write one register
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val[CFG_DATA_BITS-1:0]);
  endtask

  task automatic set_pacing(int mode);
    case (mode)
      0: begin tx_idle_pct = 33; rx_idle_pct = 86; end
      1: begin tx_idle_pct = 86; rx_idle_pct = 33; end
      default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
    endcase
  endtask

  // One line: mostly well formed near the screen, some anywhere, some noise
  task automatic random_line();
    int pick, reach, x0, y0, x1, y1, len, n;
    in_item_t it;
    pick = $urandom_range(0, 99);
    if (pick >= 88) begin
      it = random_item();
      send_item(it);
      if (it.op == OP_START) send_steps($urandom_range(0, 6));
      return;
    end
    if (pick < 70) begin
      x0 = clip_coord(int'($urandom_range(0, int'(sb.scr_w) + 32)) - 16);
      y0 = clip_coord(int'($urandom_range(0, int'(sb.scr_h) + 32)) - 16);
    end else begin
      x0 = rand_coord();
      y0 = rand_coord();
    end
    pick  = $urandom_range(0, 99);
    reach = (pick < 40) ? 3 : (pick < 90) ? 16 : 120;
    x1 = clip_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
    y1 = clip_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
    send_start(x0, y0, x1, y1, $urandom_range(0, 1));
    len = line_steps(x0, y0, x1, y1);
    case ($urandom_range(0, 9))
      0: n = $urandom_range(0, len - 1);
      1: n = len + $urandom_range(1, 2);
      default: n = len;
    endcase
    send_steps(n);
  endtask

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_pacing(0);

    // Directed: idle step, single-pixel line, coordinate extremes
    send_steps(1);
    send_start(0, 0, 0, 0, 1'b1);
    send_steps(1);
    send_start(2047, 2047, 2046, 2047, 1'b0);
    send_steps(2);
    // Drop a line midway and restart across the screen corner
    send_start(-2048, -2048, -2048, -2047, 1'b1);
    send_steps(1);
    send_start(126, 62, 129, 65, 1'b1);
    send_steps(5);
    // Zero width, then zero height: nothing is on screen
    write_reg(REG_SCREEN_WIDTH, 0);
    send_start(0, 0, 0, 0, 1'b1);
    send_steps(1);
    write_reg(REG_SCREEN_WIDTH, 128);
    write_reg(REG_SCREEN_HEIGHT, 0);
    send_start(3, 3, 3, 3, 1'b1);
    send_steps(1);
    // On screen, but past the end of a small buffer
    write_reg(REG_SCREEN_HEIGHT, 64);
    write_reg(REG_BUFFER_BYTES, 16);
    send_start(14, 0, 17, 0, 1'b1);
    send_steps(4);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      set_pacing(ph / 2);
      case (ph)
        0: begin
          write_reg(REG_SCREEN_WIDTH, 128);
          write_reg(REG_SCREEN_HEIGHT, 64);
          write_reg(REG_BUFFER_BYTES, 1024);
        end
        1: begin
          write_reg(REG_SCREEN_WIDTH, 1024);
          write_reg(REG_SCREEN_HEIGHT, 1024);
          write_reg(REG_BUFFER_BYTES, 65535);
        end
        2: begin
          write_reg(REG_SCREEN_WIDTH, 1);
          write_reg(REG_SCREEN_HEIGHT, 1);
          write_reg(REG_BUFFER_BYTES, 0);
        end
        3: begin
          write_reg(REG_SCREEN_WIDTH, $urandom_range(1, 2047));
          write_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 2047));
          write_reg(REG_BUFFER_BYTES, $urandom_range(0, 65535));
          write_reg(REG_UNUSED, $urandom_range(0, 65535));
        end
        4: begin
          write_reg(REG_SCREEN_WIDTH, 2047);
          write_reg(REG_SCREEN_HEIGHT, 2047);
          write_reg(REG_BUFFER_BYTES, $urandom_range(0, 65535));
        end
        default: begin
          write_reg(REG_SCREEN_WIDTH, 96);
          write_reg(REG_SCREEN_HEIGHT, 40);
          write_reg(REG_BUFFER_BYTES, 300);
        end
      endcase
      // Stall the receiver while a long line keeps the input busy
      if (ph == 0 || ph == 4) begin
        hold_req = 1'b1;
        send_start(0, 0, 60, -20, 1'b1);
        send_steps(40);
      end
      goal = sb.live_count + PHASE_ITEMS;
      while (sb.live_count < goal) random_line();
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("line_rasterizer_page_framebuffer_top regression: pass");
    end else begin
      $display("line_rasterizer_page_framebuffer_top regression: fail");
    end
    $finish;
  end

endmodule
